@@ rtl/dqs_pkg.sv @@
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types and constants of the dual quaternion skinning blender.
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int NCOMP    = 8;   // real w,x,y,z then dual w,x,y,z
  localparam int COMP_W   = 24;  // Q7.16
  localparam int SUM_W    = 48;  // Q31.16 accumulators
  localparam int NORM_W   = 30;  // real sums are scaled below 2^30 for the norm
  localparam int SH_MAX   = SUM_W - NORM_W;
  localparam int ONE_Q16  = 65536;

  // Steps of the accumulate sequence: 4 dot products, 8 weighted terms, drain
  localparam logic [4:0] ACC_LAST  = 5'd12;
  localparam logic [4:0] SQ_LAST   = 5'd5;
  localparam logic [4:0] SQRT_LAST = 5'd30;
  localparam logic [4:0] DIV_LAST  = 5'd23;

  typedef enum logic [1:0] {
    K_INFL,
    K_LAST,
    K_IDENT
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic [15:0]                   vid;
    logic [16:0]                   weight;
    logic [NCOMP-1:0][COMP_W-1:0]  comp;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_OR,
    S_SHIFT,
    S_SQ,
    S_SQRT,
    S_HOLD,
    S_DIV_LOAD,
    S_DIV_STEP,
    S_DIV_STORE,
    S_EMIT_ID
  } bstate_t;

  function automatic logic [SUM_W-1:0] mag48(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

endpackage

@@ rtl/dual_quaternion_skinning_vertex.sv @@
// ----------------------------------------------------------------------------
// dual_quaternion_skinning_vertex
// Blends the joint dual quaternions of one vertex and normalises the result.
// ----------------------------------------------------------------------------
// Each pushed item is one joint influence; the one marked last closes the
// vertex and yields one normalised Q7.16 dual quaternion, and an identity
// command yields the identity without blending. Influences wait in a short
// input queue; the blending engine finishes each influence before taking the
// next, sharing one 25x24 multiplier for the four pivot dot products and the
// eight weighted terms. Closing a vertex then gathers the real sums, finds
// the scale shift, squares, takes a bit-serial square root and runs eight
// restoring divisions, one quotient bit per cycle. A finished result sits
// in an output register until popped, while the queue keeps taking
// influences.
module dual_quaternion_skinning_vertex
  import dqs_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               command,
  input  logic [15:0]        vertex_id,
  input  logic [16:0]        weight,
  input  logic signed [23:0] real_w,
  input  logic signed [23:0] real_x,
  input  logic signed [23:0] real_y,
  input  logic signed [23:0] real_z,
  input  logic signed [23:0] dual_w,
  input  logic signed [23:0] dual_x,
  input  logic signed [23:0] dual_y,
  input  logic signed [23:0] dual_z,
  input  logic               last_influence,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        out_vertex_id,
  output logic signed [23:0] out_real_w,
  output logic signed [23:0] out_real_x,
  output logic signed [23:0] out_real_y,
  output logic signed [23:0] out_real_z,
  output logic signed [23:0] out_dual_w,
  output logic signed [23:0] out_dual_x,
  output logic signed [23:0] out_dual_y,
  output logic signed [23:0] out_dual_z,
  output logic               degenerate
);

  logic [NCOMP-1:0][COMP_W-1:0] in_comp;
  logic [NCOMP-1:0][COMP_W-1:0] o_comp;
  logic                         q_valid;
  logic                         q_pop;
  item_t                        q_item;

  assign in_comp = {dual_z, dual_y, dual_x, dual_w, real_z, real_y, real_x, real_w};

  dqs_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .vid            (vertex_id),
    .weight         (weight),
    .comp           (in_comp),
    .last_influence (last_influence),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  dqs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .o_vid   (out_vertex_id),
    .o_comp  (o_comp),
    .o_deg   (degenerate)
  );

  assign out_real_w = $signed(o_comp[0]);
  assign out_real_x = $signed(o_comp[1]);
  assign out_real_y = $signed(o_comp[2]);
  assign out_real_z = $signed(o_comp[3]);
  assign out_dual_w = $signed(o_comp[4]);
  assign out_dual_x = $signed(o_comp[5]);
  assign out_dual_y = $signed(o_comp[6]);
  assign out_dual_z = $signed(o_comp[7]);

endmodule

@@ rtl/dqs_front.sv @@
// ----------------------------------------------------------------------------
// dqs_front
// Input side: classifies each influence and holds it in a short queue.
// ----------------------------------------------------------------------------
module dqs_front
  import dqs_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         command,
  input  logic [15:0]                  vid,
  input  logic [16:0]                  weight,
  input  logic [NCOMP-1:0][COMP_W-1:0] comp,
  input  logic                         last_influence,
  output logic                         q_valid,
  output item_t                        q_item,
  input  logic                         q_pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          do_wr;
  logic          do_rd;
  item_t         in_item;

  always_comb begin
    in_item.kind   = command ? K_IDENT : (last_influence ? K_LAST : K_INFL);
    in_item.vid    = vid;
    in_item.weight = weight;
    in_item.comp   = comp;
  end

  assign full    = (cnt == CW'(QDEPTH));
  assign q_valid = (cnt != '0);
  assign q_item  = mem[rd_ptr];
  assign do_wr   = push && !full;
  assign do_rd   = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QDEPTH)) else $error("queue count above depth");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_grow: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> cnt == CW'($past(cnt) + 1'b1))
    else $error("queue count did not grow on transfer in");
`endif

endmodule

@@ rtl/dqs_back.sv @@
// ----------------------------------------------------------------------------
// dqs_back
// Execution side: accumulates weighted influences, then normalises the
// blended dual quaternion by a square root and restoring division.
// ----------------------------------------------------------------------------
module dqs_back
  import dqs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  item_t                        q_item,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [15:0]                  o_vid,
  output logic [NCOMP-1:0][COMP_W-1:0] o_comp,
  output logic                         o_deg
);

  bstate_t state, state_next;
  item_t   cur;
  logic    have_pivot;
  logic signed [COMP_W-1:0] pivot [4];
  logic signed [SUM_W-1:0]  blend [NCOMP];
  logic [4:0]  cnt;
  logic        id_deg;

  logic               mvalid;
  logic               mdot;
  logic [2:0]         midx;
  logic signed [48:0] mprod;
  logic signed [49:0] dot_acc;
  logic signed [24:0] mul_a;
  logic signed [23:0] mul_b;
  logic [2:0]         mul_idx;
  logic               mul_issue;

  logic [SUM_W-1:0]   orm;
  logic [SUM_W-1:0]   orm_upd;
  logic [4:0]         sh;
  logic [NORM_W-1:0]  sq_m;
  logic [59:0]        sqprod;
  logic [61:0]        n2;
  logic [30:0]        root;
  logic [32:0]        srem;
  logic [34:0]        sq_shift;
  logic [34:0]        sq_trial;

  logic [2:0]         dcomp;
  logic [49:0]        divisor;
  logic [49:0]        drem;
  logic [23:0]        dx;
  logic [23:0]        quo;
  logic               dovf;
  logic [50:0]        dv_shift;
  logic [COMP_W-1:0]  sat_val;

  logic [2:0]              rd_idx;
  logic signed [SUM_W-1:0] rd;
  logic [SUM_W-1:0]        rd_mag;
  logic signed [48:0]      pn;
  logic signed [48:0]      rnd;
  logic signed [32:0]      term;
  logic signed [48:0]      sumx;
  logic signed [SUM_W-1:0] sum_sat;

  logic emit_div;
  logic emit_id;
  logic do_clear;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (q_valid) state_next = (q_item.kind == K_IDENT) ? S_EMIT_ID : S_ACC;
      S_ACC:       if (cnt == ACC_LAST) state_next = (cur.kind == K_LAST) ? S_OR : S_IDLE;
      S_OR:        if (cnt == 5'd3) state_next = (orm_upd == '0) ? S_EMIT_ID : S_SHIFT;
      S_SHIFT:     if (orm[SUM_W-1:NORM_W] == '0) state_next = S_SQ;
      S_SQ:        if (cnt == SQ_LAST) state_next = S_SQRT;
      S_SQRT:      if (cnt == SQRT_LAST) state_next = S_HOLD;
      S_HOLD:      if (!empty) state_next = S_HOLD; else state_next = S_DIV_LOAD;
      S_DIV_LOAD:  state_next = S_DIV_STEP;
      S_DIV_STEP:  if (cnt == DIV_LAST) state_next = S_DIV_STORE;
      S_DIV_STORE: state_next = (dcomp == 3'd7) ? S_IDLE : S_DIV_LOAD;
      S_EMIT_ID:   if (empty) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    q_pop     = (state == S_IDLE) && q_valid;
    mul_issue = (state == S_ACC) && (cnt < ACC_LAST);
    emit_div  = (state == S_DIV_STORE) && (dcomp == 3'd7);
    emit_id   = (state == S_EMIT_ID) && empty;
    do_clear  = emit_div || emit_id;
    unique case (state)
      S_OR, S_SQ:                                  rd_idx = {1'b0, cnt[1:0]};
      S_HOLD, S_DIV_LOAD, S_DIV_STEP, S_DIV_STORE: rd_idx = dcomp;
      default:                                     rd_idx = midx;
    endcase
  end

  assign rd     = blend[rd_idx];
  assign rd_mag = mag48(rd);

  // Shared multiplier operands: dot products first, then weighted terms
  always_comb begin
    if (cnt < 5'd4) begin
      mul_idx = {1'b0, cnt[1:0]};
      mul_a   = 25'(pivot[cnt[1:0]]);
    end else begin
      mul_idx = 3'(cnt - 5'd4);
      mul_a   = $signed({8'd0, cur.weight});
    end
    mul_b = $signed(cur.comp[mul_idx]);
  end

  // Weighted term, rounded half up, added with saturation
  always_comb begin
    pn   = dot_acc[49] ? -mprod : mprod;
    rnd  = pn + 49'sd32768;
    term = rnd[48:16];
    sumx = 49'(rd) + 49'(term);
    if (sumx[48] != sumx[47]) begin
      sum_sat = sumx[48] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sumx[SUM_W-1:0];
    end
  end

  assign orm_upd  = ((cnt == '0) ? '0 : orm) | rd_mag;
  assign sq_shift = {srem, n2[61:60]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign dv_shift = {drem, dx[23]};

  always_comb begin
    if (!rd[SUM_W-1]) begin
      sat_val = (dovf || quo >= 24'h7FFFFF) ? 24'h7FFFFF : quo;
    end else begin
      sat_val = (dovf || quo >= 24'h800000) ? 24'h800000 : 24'(-quo);
    end
  end

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      have_pivot <= 1'b0;
      mvalid     <= 1'b0;
      empty      <= 1'b1;
      sh         <= '0;
      for (int i = 0; i < NCOMP; i++) blend[i] <= '0;
      for (int i = 0; i < 4; i++) pivot[i] <= '0;
    end else begin
      state  <= state_next;
      cnt    <= (state != state_next) ? '0 : cnt + 1'b1;
      mvalid <= mul_issue;

      if (q_pop && q_item.kind != K_IDENT && !have_pivot) begin
        have_pivot <= 1'b1;
        for (int i = 0; i < 4; i++) pivot[i] <= $signed(q_item.comp[i]);
      end

      if (mvalid && !mdot) begin
        blend[midx] <= sum_sat;
      end

      if (state == S_OR) begin
        sh <= '0;
      end else if (state == S_SHIFT && orm[SUM_W-1:NORM_W] != '0) begin
        sh <= sh + 1'b1;
      end

      if (!empty && pop) begin
        empty <= 1'b1;
      end else if (do_clear) begin
        empty <= 1'b0;
      end

      if (do_clear) begin
        have_pivot <= 1'b0;
        for (int i = 0; i < NCOMP; i++) blend[i] <= '0;
        for (int i = 0; i < 4; i++) pivot[i] <= '0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_item;
      dot_acc <= '0;
      id_deg  <= 1'b0;
    end
    if (mul_issue) begin
      mprod <= mul_a * mul_b;
      mdot  <= (cnt < 5'd4);
      midx  <= mul_idx;
    end
    if (mvalid && mdot) begin
      dot_acc <= dot_acc + 50'(mprod);
    end

    unique case (state)
      S_OR: begin
        orm <= orm_upd;
        if (cnt == 5'd3 && orm_upd == '0) id_deg <= 1'b1;
      end
      S_SHIFT: begin
        if (orm[SUM_W-1:NORM_W] != '0) orm <= orm >> 1;
      end
      S_SQ: begin
        sq_m   <= NORM_W'(rd_mag >> sh);
        sqprod <= sq_m * sq_m;
        n2     <= (cnt <= 5'd1) ? '0 : n2 + 62'(sqprod);
        root   <= '0;
        srem   <= '0;
      end
      S_SQRT: begin
        n2 <= n2 << 2;
        if (sq_shift >= sq_trial) begin
          srem <= 33'(sq_shift - sq_trial);
          root <= {root[29:0], 1'b1};
        end else begin
          srem <= 33'(sq_shift);
          root <= {root[29:0], 1'b0};
        end
      end
      S_HOLD: begin
        divisor <= 50'(root) << sh;
        dcomp   <= '0;
      end
      S_DIV_LOAD: begin
        drem <= 50'(rd_mag >> 8);
        dx   <= {rd_mag[7:0], 16'd0};
        dovf <= (50'(rd_mag >> 8) >= divisor);
        quo  <= '0;
      end
      S_DIV_STEP: begin
        dx <= dx << 1;
        if (dv_shift >= {1'b0, divisor}) begin
          drem <= 50'(dv_shift - {1'b0, divisor});
          quo  <= {quo[22:0], 1'b1};
        end else begin
          drem <= 50'(dv_shift);
          quo  <= {quo[22:0], 1'b0};
        end
      end
      S_DIV_STORE: begin
        o_comp[dcomp] <= sat_val;
        dcomp         <= dcomp + 1'b1;
        if (emit_div) begin
          o_vid <= cur.vid;
          o_deg <= 1'b0;
        end
      end
      S_EMIT_ID: begin
        if (emit_id) begin
          o_vid <= cur.vid;
          o_deg <= id_deg;
          o_comp[0] <= COMP_W'(ONE_Q16);
          for (int i = 1; i < NCOMP; i++) o_comp[i] <= '0;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_cleared: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> !have_pivot) else $error("vertex state left after result");
  a_degen_ident: assert property (@(posedge clk) disable iff (rst)
    (!empty && o_deg) |-> o_comp[0] == COMP_W'(ONE_Q16))
    else $error("degenerate result is not the identity");
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    sh <= 5'(SH_MAX)) else $error("normalising shift out of range");
`endif

endmodule

@@ verif/tb_dual_quaternion_skinning_vertex.sv @@
// ----------------------------------------------------------------------------
// tb_dual_quaternion_skinning_vertex
// Self-checking bench for the dual quaternion skinning blender.
// ----------------------------------------------------------------------------
// A queue of joint influences feeds a clocked driver. A bit-exact blend model
// predicts each vertex result as items are taken. A clocked monitor checks
// every popped result against the oldest prediction. Both sides idle in random
// bursts. The receiver holds off once for a long stretch so that the input
// fills. The sender pauses twice until all predicted poses have drained.
// ----------------------------------------------------------------------------
module tb_dual_quaternion_skinning_vertex;
  import dqs_pkg::*;

  typedef struct packed {
    logic                  cmd;
    logic [15:0]           vid;
    logic [16:0]           wt;
    logic [7:0][23:0]      comp;
    logic                  last;
    logic                  hold;
  } influence_t;

  typedef struct packed {
    logic [15:0]           vid;
    logic [7:0][23:0]      q;
    logic                  degen;
  } pose_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CALM_TAIL      = 120;
  localparam int HOLDOFF_LEN    = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, degenerate;
  logic command = 1'b0, last_influence = 1'b0;
  logic [15:0] vertex_id = '0;
  logic [16:0] weight = '0;
  logic signed [23:0] real_w = '0, real_x = '0, real_y = '0, real_z = '0;
  logic signed [23:0] dual_w = '0, dual_x = '0, dual_y = '0, dual_z = '0;
  logic [15:0] out_vertex_id;
  logic signed [23:0] out_real_w, out_real_x, out_real_y, out_real_z;
  logic signed [23:0] out_dual_w, out_dual_x, out_dual_y, out_dual_z;

  dual_quaternion_skinning_vertex u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .vertex_id(vertex_id), .weight(weight),
    .real_w(real_w), .real_x(real_x), .real_y(real_y), .real_z(real_z),
    .dual_w(dual_w), .dual_x(dual_x), .dual_y(dual_y), .dual_z(dual_z),
    .last_influence(last_influence), .empty(empty), .pop(pop),
    .out_vertex_id(out_vertex_id),
    .out_real_w(out_real_w), .out_real_x(out_real_x),
    .out_real_y(out_real_y), .out_real_z(out_real_z),
    .out_dual_w(out_dual_w), .out_dual_x(out_dual_x),
    .out_dual_y(out_dual_y), .out_dual_z(out_dual_z),
    .degenerate(degenerate)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  influence_t influence_q[$];
  pose_t      expected_poses[$];
  bit         loaded = 1'b0;
  bit         took_in = 1'b0;
  int         errors = 0;
  int         popped = 0;

  // blend state
  logic signed [23:0] pivot[4];
  longint             sums[8];
  bit                 have_pivot;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] normalise(longint sum, longint unsigned n, int s);
    longint unsigned a, q, q1, r1;
    int d;
    a = (sum < 0) ? longint'(-sum) : sum;
    d = 16 - s;
    if (d >= 0) begin
      q1 = a / n;
      r1 = a % n;
      if ((q1 >> (23 - d)) != 0) q = 64'd1 << 23;
      else q = (q1 << d) + ((r1 << d) / n);
    end else begin
      q = (a >> (-d)) / n;
    end
    if (sum < 0) return (q >= 64'h800000) ? 24'h800000 : 24'(-longint'(q));
    return (q >= 64'h7FFFFF) ? 24'h7FFFFF : q[23:0];
  endfunction

  function automatic pose_t identity_pose(logic [15:0] vid, logic degen);
    pose_t p;
    p = '0;
    p.vid = vid;
    p.q[0] = 24'(ONE_Q16);
    p.degen = degen;
    return p;
  endfunction

  function automatic void clear_blend();
    for (int i = 0; i < 4; i++) pivot[i] = '0;
    for (int i = 0; i < 8; i++) sums[i] = 0;
    have_pivot = 1'b0;
  endfunction

  // Fold one influence into the blend; returns 1 when a pose is due.
  function automatic bit blend_influence(influence_t it, output pose_t pose);
    longint c[8], w, dot, p, v;
    longint unsigned mags[4], n2, n;
    int s;
    bit big;
    pose = '0;
    if (it.cmd) begin
      clear_blend();
      pose = identity_pose(it.vid, 1'b0);
      return 1'b1;
    end
    for (int i = 0; i < 8; i++) c[i] = $signed(it.comp[i]);
    if (!have_pivot) begin
      for (int i = 0; i < 4; i++) pivot[i] = it.comp[i];
      have_pivot = 1'b1;
    end
    dot = 0;
    for (int i = 0; i < 4; i++) dot += longint'(pivot[i]) * c[i];
    w = it.wt;
    if (dot < 0) w = -w;
    for (int i = 0; i < 8; i++) begin
      p = w * c[i];
      v = sums[i] + ((p + 32768) >>> 16);
      if (v > 64'sh7FFFFFFFFFFF) v = 64'sh7FFFFFFFFFFF;
      if (v < -64'sh800000000000) v = -64'sh800000000000;
      sums[i] = v;
    end
    if (!it.last) return 1'b0;
    for (int i = 0; i < 4; i++) mags[i] = (sums[i] < 0) ? longint'(-sums[i]) : sums[i];
    s = 0;
    do begin
      big = 1'b0;
      for (int i = 0; i < 4; i++) if ((mags[i] >> s) >= (64'd1 << 30)) big = 1'b1;
      if (big) s++;
    end while (big);
    n2 = 0;
    for (int i = 0; i < 4; i++) n2 += (mags[i] >> s) * (mags[i] >> s);
    n = isqrt(n2);
    if (n == 0) begin
      pose = identity_pose(it.vid, 1'b1);
    end else begin
      pose.vid = it.vid;
      for (int i = 0; i < 8; i++) pose.q[i] = normalise(sums[i], n, s);
      pose.degen = 1'b0;
    end
    clear_blend();
    return 1'b1;
  endfunction

  function automatic influence_t make_influence(logic cmd, logic [15:0] vid,
      logic [16:0] wt, logic [7:0][23:0] comp, logic last);
    influence_t it;
    it.cmd = cmd; it.vid = vid; it.wt = wt; it.comp = comp;
    it.last = last; it.hold = 1'b0;
    return it;
  endfunction

  function automatic logic [23:0] random_comp(int mode);
    case (mode)
      0:       return 24'($urandom_range(0, 131072)) - 24'd65536;
      1:       return 24'($urandom);
      default: return 24'($urandom_range(0, 255)) - 24'd128;
    endcase
  endfunction

  function automatic void queue_random_vertex();
    int cnt, mode;
    logic [15:0] vid;
    logic [16:0] wt;
    logic [7:0][23:0] comp;
    vid = 16'($urandom);
    if ($urandom_range(0, 11) == 0) begin
      // identity command with random content on the other fields
      for (int i = 0; i < 8; i++) comp[i] = 24'($urandom);
      influence_q.push_back(make_influence(1'b1, vid, 17'($urandom), comp,
                                           1'($urandom)));
      return;
    end
    cnt = $urandom_range(1, 4);
    for (int k = 0; k < cnt; k++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 0 : (mode < 9) ? 1 : 2;
      for (int i = 0; i < 8; i++) comp[i] = random_comp(mode);
      if ($urandom_range(0, 19) == 0) for (int i = 0; i < 4; i++) comp[i] = '0;
      case ($urandom_range(0, 9))
        0:       wt = 17'($urandom);
        1:       wt = '0;
        default: wt = 17'($urandom_range(0, 65536));
      endcase
      // a broken vertex now and then: lose the last mark or cut in with identity
      if (k == cnt - 1 && $urandom_range(0, 19) == 0) begin
        influence_q.push_back(make_influence(1'b0, vid, wt, comp, 1'b0));
        if ($urandom_range(0, 1) == 0)
          influence_q.push_back(make_influence(1'b1, vid, wt, comp, 1'b0));
      end else begin
        influence_q.push_back(make_influence(1'b0, vid, wt, comp, k == cnt - 1));
      end
    end
  endfunction

  // Directed items then random vertices.
  initial begin
    logic [7:0][23:0] c;
    c = '0;
    influence_q.push_back(make_influence(1'b1, 16'h0000, '0, c, 1'b0));
    c[0] = 24'd65536; c[5] = 24'd1000; c[6] = -24'sd2000;
    influence_q.push_back(make_influence(1'b0, 16'h0001, 17'd65536, c, 1'b1));
    c = '0; c[0] = 24'd46341; c[1] = 24'd46341; c[4] = 24'd500;
    influence_q.push_back(make_influence(1'b0, 16'h0002, 17'd32768, c, 1'b0));
    c[0] = -24'sd46341; c[1] = -24'sd46341; c[4] = -24'sd700; c[7] = 24'd300;
    influence_q.push_back(make_influence(1'b0, 16'h0002, 17'd32768, c, 1'b1));
    c = '0; c[0] = 24'd65536; c[4] = 24'd99;
    influence_q.push_back(make_influence(1'b0, 16'h0003, 17'd0, c, 1'b1));
    c = '0; c[4] = 24'd4000; c[7] = -24'sd4000;
    influence_q.push_back(make_influence(1'b0, 16'h0004, 17'd65536, c, 1'b1));
    for (int i = 0; i < 8; i++) c[i] = 24'h7FFFFF;
    influence_q.push_back(make_influence(1'b0, 16'hFFFF, 17'h1FFFF, c, 1'b1));
    for (int i = 0; i < 8; i++) c[i] = 24'h800000;
    influence_q.push_back(make_influence(1'b0, 16'h8000, 17'h1FFFF, c, 1'b0));
    influence_q.push_back(make_influence(1'b0, 16'h8000, 17'h10000, c, 1'b1));
    c = '0; c[0] = 24'd1; c[4] = 24'h7FFFFF; c[5] = 24'h800000;
    c[6] = 24'h7FFFFF; c[7] = 24'h800000;
    influence_q.push_back(make_influence(1'b0, 16'h0005, 17'd65536, c, 1'b1));
    c = '0; c[0] = 24'd65536; c[2] = 24'd12345;
    influence_q.push_back(make_influence(1'b0, 16'h0006, 17'd40000, c, 1'b0));
    influence_q.push_back(make_influence(1'b1, 16'h0007, 17'd40000, c, 1'b1));
    c = '0; c[3] = 24'd65536; c[1] = 24'd3;
    influence_q.push_back(make_influence(1'b0, 16'h0008, 17'd65536, c, 1'b0));
    c[3] = 24'd0; c[1] = -24'sd65536;
    influence_q.push_back(make_influence(1'b0, 16'h0008, 17'd65535, c, 1'b1));
    c = '0; c[0] = 24'd65536;
    influence_q.push_back(make_influence(1'b1, 16'hAAAA, 17'h15555, c, 1'b1));
    influence_q.push_back(make_influence(1'b0, 16'h5555, 17'h0AAAA, c, 1'b1));
    while (influence_q.size() < 1150) queue_random_vertex();
    influence_q[300].hold = 1'b1;
    influence_q[700].hold = 1'b1;
    loaded = 1'b1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (influence_q.size() == 0 && expected_poses.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("dual_quaternion_skinning_vertex: match");
    else $display("dual_quaternion_skinning_vertex: mismatch");
    $finish;
  end

  wire calm = loaded && influence_q.size() < CALM_TAIL;

  // Sender: hold the front item until it transfers, idle in bursts otherwise.
  int send_gap = 0;
  always @(negedge clk) begin
    bit go;
    influence_t it;
    go = 1'b0;
    if (!rst) begin
      if (took_in) void'(influence_q.pop_front());
      if (push && !took_in) begin
        go = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (influence_q.size() > 0) begin
        if (influence_q[0].hold && expected_poses.size() != 0) begin
          go = 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 7);
        end else begin
          influence_q[0].hold = 1'b0;
          go = 1'b1;
        end
      end
      if (go) begin
        it = influence_q[0];
        command <= it.cmd; vertex_id <= it.vid; weight <= it.wt;
        real_w <= it.comp[0]; real_x <= it.comp[1];
        real_y <= it.comp[2]; real_z <= it.comp[3];
        dual_w <= it.comp[4]; dual_x <= it.comp[5];
        dual_y <= it.comp[6]; dual_z <= it.comp[7];
        last_influence <= it.last;
      end
    end
    push <= go;
  end

  // Receiver: one long hold-off early on, then random bursts.
  int recv_gap = 0;
  int holdoff = 0;
  bit held_once = 1'b0;
  always @(negedge clk) begin
    bit take;
    take = 1'b0;
    if (!rst) begin
      if (!held_once && popped == 40) begin
        held_once = 1'b1;
        holdoff = HOLDOFF_LEN;
      end
      if (holdoff > 0) holdoff--;
      else if (recv_gap > 0) recv_gap--;
      else if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 7);
      else take = 1'b1;
    end
    pop <= take;
  end

  // Monitor: predict on input transfers, check on output transfers.
  string comp_names[8] = '{"out_real_w", "out_real_x", "out_real_y", "out_real_z",
                           "out_dual_w", "out_dual_x", "out_dual_y", "out_dual_z"};
  always @(posedge clk) begin
    pose_t pose, want;
    logic [7:0][23:0] got;
    influence_t it;
    if (rst) begin
      clear_blend();
      took_in = 1'b0;
    end else begin
      took_in = push && !full;
      if (took_in) begin
        it = make_influence(command, vertex_id, weight,
                            {dual_z, dual_y, dual_x, dual_w,
                             real_z, real_y, real_x, real_w}, last_influence);
        if (blend_influence(it, pose)) expected_poses.push_back(pose);
      end
      if (pop && !empty) begin
        popped++;
        got = {out_dual_z, out_dual_y, out_dual_x, out_dual_w,
               out_real_z, out_real_y, out_real_x, out_real_w};
        if (expected_poses.size() == 0) begin
          $error("unexpected pose for vertex %0d", out_vertex_id);
          errors++;
        end else begin
          want = expected_poses.pop_front();
          if (out_vertex_id !== want.vid) begin
            $error("out_vertex_id expected %0d got %0d", want.vid, out_vertex_id);
            errors++;
          end
          for (int i = 0; i < 8; i++)
            if (got[i] !== want.q[i]) begin
              $error("%s expected %0d got %0d", comp_names[i],
                     $signed(want.q[i]), $signed(got[i]));
              errors++;
            end
          if (degenerate !== want.degen) begin
            $error("degenerate expected %0d got %0d", want.degen, degenerate);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dual_quaternion_skinning_vertex: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
